### sv/base64_stream_decoder_unit_defines.svh
// Assertion helpers used by the checker of the decoder.
// Each expects clk_i and rst_ni in scope.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define B64SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/b64sd_pkg.sv
`timescale 1ns / 1ps
package b64sd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned SYM_W       = 7;
  localparam int unsigned NUM_BYTES   = 3;

  localparam logic [5:0] SYM_PLUS  = 6'd62;
  localparam logic [5:0] SYM_SLASH = 6'd63;
  localparam logic [5:0] SYM_DIGIT = 6'd52;

  localparam logic [SYM_W-1:0] SYM_INVALID = 7'h40;

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_done;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [NUM_BYTES-1:0][7:0] bytes;
    logic [NUM_BYTES-1:0]      byte_en;
    logic                      eom;
  } job_t;

  function automatic logic [SYM_W-1:0] classify(input logic [7:0] ch);
    logic [SYM_W-1:0] code;
    code = SYM_INVALID;
    if (ch inside {[8'h41:8'h5A]}) begin
      code = {1'b0, 6'(ch - 8'h41)};
    end else if (ch inside {[8'h61:8'h7A]}) begin
      code = {1'b0, 6'(ch - 8'h47)};
    end else if (ch inside {[8'h30:8'h39]}) begin
      code = {1'b0, 6'(ch[3:0]) + SYM_DIGIT};
    end else if (ch == 8'h2B) begin
      code = {1'b0, SYM_PLUS};
    end else if (ch == 8'h2F) begin
      code = {1'b0, SYM_SLASH};
    end
    return code;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch inside {8'h0A, 8'h0D, 8'h09, 8'h20};
  endfunction

endpackage

### sv/b64sd_front.sv
`timescale 1ns / 1ps
module b64sd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  b64sd_pkg::in_t  in_item_i,
  input  logic            q_full_i,
  output logic            push_o,
  output b64sd_pkg::job_t job_o
);
  import b64sd_pkg::*;

  logic [SYM_W-1:0] held_q [0:2];
  logic [SYM_W-1:0] held_d [0:2];
  logic [1:0]       pos_q, pos_d;
  logic             stop_q, stop_d;
  logic             accept;
  logic             active;
  logic [SYM_W-1:0] code;
  logic [SYM_W-1:0] sa, sb, sc;
  logic [1:0]       c_low;
  job_t             job;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    code   = classify(in_item_i.symbol_byte);
    active = !is_blank(in_item_i.symbol_byte) && !stop_q;
    sa     = held_q[0];
    sb     = held_q[1];
    sc     = held_q[2];
    c_low  = sc[6] ? 2'b11 : sc[1:0];
    held_d = held_q;
    pos_d  = pos_q;
    stop_d = stop_q;
    job.bytes[0] = {sa[5:0], sb[5:4]};
    job.bytes[1] = {sb[3:0], sc[5:2]};
    job.bytes[2] = {c_low, code[5:0]};
    job.byte_en  = '0;
    job.eom      = in_item_i.end_of_message;
    if (active) begin
      if (pos_q != 2'd3) begin
        held_d[pos_q] = code;
        pos_d         = pos_q + 2'd1;
      end else begin
        pos_d = 2'd0;
        if (sa[6] || sb[6]) begin
          stop_d = 1'b1;
        end else begin
          job.byte_en = {!code[6], !sc[6], 1'b1};
        end
      end
    end
    if (in_item_i.end_of_message) begin
      held_d = '{default: '0};
      pos_d  = 2'd0;
      stop_d = 1'b0;
    end
  end

  assign push_o = accept && ((|job.byte_en) || job.eom);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '{default: '0};
      pos_q  <= 2'd0;
      stop_q <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
      pos_q  <= pos_d;
      stop_q <= stop_d;
    end
  end

endmodule

### sv/b64sd_queue.sv
`timescale 1ns / 1ps
module b64sd_queue #(
  parameter int unsigned Depth = b64sd_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64sd_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output b64sd_pkg::job_t head_o
);
  import b64sd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

### sv/b64sd_back.sv
`timescale 1ns / 1ps
module b64sd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  b64sd_pkg::job_t q_head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output b64sd_pkg::out_t out_item_o
);
  import b64sd_pkg::*;

  logic [NUM_BYTES:0]        rem_q, rem_d, rem_after, pick;
  logic [NUM_BYTES-1:0][7:0] bytes_q;
  logic                      out_valid_q, out_valid_d;
  out_t                      out_q, res;
  logic                      can_emit, emit, need_load;

  always_comb begin
    if (rem_q[0]) begin
      pick = 4'b0001;
      res.data_byte = bytes_q[0];
    end else if (rem_q[1]) begin
      pick = 4'b0010;
      res.data_byte = bytes_q[1];
    end else if (rem_q[2]) begin
      pick = 4'b0100;
      res.data_byte = bytes_q[2];
    end else begin
      pick = 4'b1000;
      res.data_byte = 8'd0;
    end
    rem_after        = rem_q & ~pick;
    res.byte_valid   = !pick[NUM_BYTES];
    res.message_done = pick[NUM_BYTES];
    res.last_of_run  = rem_after == '0;
  end

  assign can_emit  = !out_valid_q || !out_stall_i;
  assign emit      = (rem_q != '0) && can_emit;
  assign need_load = (rem_q == '0) || (emit && rem_after == '0);
  assign pop_o     = need_load && q_valid_i;

  always_comb begin
    rem_d = rem_q;
    if (pop_o) begin
      rem_d = {q_head_i.eom, q_head_i.byte_en};
    end else if (emit) begin
      rem_d = rem_after;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q <= q_head_i.bytes;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sv/base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload            | Handshake
// in      | input     | symbol, end flag   | in_valid_i / in_stall_o
// out     | output    | byte or end marker | out_valid_o / out_stall_i
//
// One character is taken per cycle while the job queue has room.
// The back end sends one result per cycle from its output register while
// out_stall_i is low, so an item with k results holds it until all are sent.
// The first result goes through the queue, job register and output register.
// Asynchronous reset clears group state, queue and output register at once.
// in_stall_o rises when the job queue is full; out_stall_i holds the result.
module base64_stream_decoder_unit #(
  parameter int unsigned QueueDepth = b64sd_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  b64sd_pkg::in_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output b64sd_pkg::out_t out_item_o
);
  import b64sd_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  b64sd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  b64sd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  b64sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### sv/b64sd_checker.sv
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_defines.svh"
module b64sd_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input b64sd_pkg::in_t  in_item_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input b64sd_pkg::out_t out_item_o
);

  `B64SD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out item dropped")
  `B64SD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_item_o), "out item changed")
  `B64SD_ASSERT_NOW(a_marker_form, out_valid_o && out_item_o.message_done, !out_item_o.byte_valid && out_item_o.last_of_run && out_item_o.data_byte == 8'd0, "bad end marker")
  `B64SD_ASSERT_NOW(a_kind, out_valid_o && !out_item_o.byte_valid, out_item_o.message_done, "result is neither byte nor marker")

endmodule

bind base64_stream_decoder_unit b64sd_checker u_checker (.*);

### tb/sv/b64sd_byte_checker.sv
`timescale 1ns / 1ps
module b64sd_byte_checker
  import b64sd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [6:0] BAD_SYM  = 7'h40;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam int unsigned MAX_SHOWN = 10;

  logic [6:0]  held [3];
  logic [1:0]  fill;
  logic        halted;
  out_t        expected_bytes [$];
  out_t        want;
  int unsigned mismatches = 0;

  function automatic logic [6:0] sym_code(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return {1'b0, 6'(ch - 8'h41)};
    if (ch >= "a" && ch <= "z") return {1'b0, 6'(ch - 8'h61 + 8'd26)};
    if (ch >= "0" && ch <= "9") return {1'b0, 6'(ch - 8'h30 + 8'd52)};
    if (ch == "+") return {1'b0, SYM_PLUS};
    if (ch == "/") return {1'b0, SYM_SLASH};
    return BAD_SYM;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_SP);
  endfunction

  function automatic out_t result_of(input logic [7:0] data, input logic valid,
                                     input logic done);
    out_t r;
    r.data_byte    = data;
    r.byte_valid   = valid;
    r.message_done = done;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  task automatic clear_group();
    held[0] = '0;
    held[1] = '0;
    held[2] = '0;
    fill    = '0;
    halted  = 1'b0;
  endtask

  task automatic decode_symbol(input in_t it);
    logic [6:0] code;
    logic [1:0] c_low;
    out_t       run [$];
    if (!is_space(it.symbol_byte) && !halted) begin
      code = sym_code(it.symbol_byte);
      if (fill != 2'd3) begin
        held[fill] = code;
        fill = fill + 2'd1;
      end else begin
        fill = 2'd0;
        if (held[0][6] || held[1][6]) begin
          halted = 1'b1;
        end else begin
          c_low = held[2][6] ? 2'b11 : held[2][1:0];
          run = {run, result_of({held[0][5:0], held[1][5:4]}, 1'b1, 1'b0)};
          if (!held[2][6]) begin
            run = {run, result_of({held[1][3:0], held[2][5:2]}, 1'b1, 1'b0)};
          end
          if (!code[6]) begin
            run = {run, result_of({c_low, code[5:0]}, 1'b1, 1'b0)};
          end
        end
      end
    end
    if (it.end_of_message) begin
      run = {run, result_of(8'h00, 1'b0, 1'b1)};
      clear_group();
    end
    if (run.size() > 0) begin
      run[run.size() - 1].last_of_run = 1'b1;
    end
    expected_bytes = {expected_bytes, run};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_group();
      expected_bytes.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_symbol(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: unexpected item: data %02h valid %b done %b last %b", $realtime,
                     out_item_i.data_byte, out_item_i.byte_valid,
                     out_item_i.message_done, out_item_i.last_of_run);
          end
        end else begin
          want = expected_bytes.pop_front();
          if (out_item_i.data_byte !== want.data_byte ||
              out_item_i.byte_valid !== want.byte_valid ||
              out_item_i.message_done !== want.message_done ||
              out_item_i.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("%0t: mismatch: expected data %02h valid %b done %b last %b, %s",
                       $realtime, want.data_byte, want.byte_valid, want.message_done,
                       want.last_of_run, "got:");
              $display("  data %02h valid %b done %b last %b", out_item_i.data_byte,
                       out_item_i.byte_valid, out_item_i.message_done,
                       out_item_i.last_of_run);
            end
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_bytes.size();
  end

endmodule

### tb/sv/tb_base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
module tb_base64_stream_decoder_unit;
  import b64sd_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PAD   = "=";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_SLASH = "/";

  localparam int unsigned DIRECTED_N   = 25;
  localparam int unsigned RANDOM_ITEMS = 190;
  localparam int unsigned CALM_FROM    = 160;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [7:0] DIRECTED [DIRECTED_N] = '{
    "T", "W", "F", "u", "+", "/", "9", "0", CH_LF,
    "Q", "Q", CH_PAD, "A", "Q", "Q", CH_PAD, CH_PAD,
    8'hFF, "A", "A", "A", 8'h00,
    "A", "B", "C"
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_item;
  logic        out_valid;
  logic        out_stall;
  out_t        out_item;
  int unsigned fail_count;
  int unsigned pending;
  bit          calm;
  int unsigned sent_items;

  base64_stream_decoder_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  b64sd_byte_checker byte_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic in_t blank_item();
    in_t it;
    it.end_of_message = 1'b0;
    case ($urandom_range(0, 3))
      0: it.symbol_byte = CH_TAB;
      1: it.symbol_byte = CH_LF;
      2: it.symbol_byte = CH_CR;
      default: it.symbol_byte = CH_SP;
    endcase
    return it;
  endfunction

  task automatic push_char(input in_t it, input bit may_idle);
    if (may_idle && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (sent_items >= DIRECTED_N + CALM_FROM) calm = 1'b1;
  endtask

  task automatic send_message();
    in_t msg [$];
    in_t it;
    int  kind;
    int  groups;
    int  pad_n;
    bit  quiet;
    kind   = $urandom_range(0, 9);
    groups = $urandom_range(1, 4);
    pad_n  = $urandom_range(0, 2);
    quiet  = ($urandom_range(0, 3) == 0);
    for (int g = 0; g < groups; g++) begin
      for (int k = 0; k < 4; k++) begin
        it.end_of_message = 1'b0;
        it.symbol_byte = b64_char(6'($urandom_range(0, 63)));
        if (g == groups - 1 && k >= 4 - pad_n) it.symbol_byte = CH_PAD;
        if (kind == 7 && $urandom_range(0, 4) == 0) it.symbol_byte = 8'($urandom);
        msg = {msg, it};
        if ($urandom_range(0, 7) == 0) msg = {msg, blank_item()};
      end
    end
    if (kind == 8) begin
      repeat ($urandom_range(1, 3)) void'(msg.pop_back());
    end
    if (kind == 9) begin
      msg.delete();
      repeat ($urandom_range(1, 8)) begin
        it.symbol_byte    = 8'($urandom);
        it.end_of_message = 1'b0;
        msg = {msg, it};
      end
    end
    case ($urandom_range(0, 9))
      0: ;
      1, 2: begin
        it = blank_item();
        it.end_of_message = 1'b1;
        msg = {msg, it};
      end
      default: msg[msg.size() - 1].end_of_message = 1'b1;
    endcase
    foreach (msg[i]) push_char(msg[i], !quiet);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_base64_stream_decoder_unit failed");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm) begin
        case ($urandom_range(0, 5))
          0: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            out_stall <= 1'b0;
          end
          1: repeat ($urandom_range(10, 40)) @(posedge clk);
          default: ;
        endcase
      end
    end
  end

  initial begin
    in_t it;
    in_valid   <= 1'b0;
    in_item    <= '0;
    rst_n      <= 1'b0;
    calm       = 1'b0;
    sent_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED[i]) begin
      it.symbol_byte    = DIRECTED[i];
      it.end_of_message = (i == 8) || (i == 21) || (i == 24);
      push_char(it, 1'b1);
    end
    while (sent_items < DIRECTED_N + RANDOM_ITEMS) send_message();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_base64_stream_decoder_unit passed");
    end else begin
      $display("tb_base64_stream_decoder_unit failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/b64sd_pkg.sv
sv/b64sd_front.sv
sv/b64sd_queue.sv
sv/b64sd_back.sv
sv/base64_stream_decoder_unit.sv
sv/b64sd_checker.sv
tb/sv/b64sd_byte_checker.sv
tb/sv/tb_base64_stream_decoder_unit.sv
